[design/stable_min_priority_queue_core_assert.svh]
// Assertion macros shared by the queue RTL.
`ifndef STABLE_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SMPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smpq assertion failed");

// next-cycle implication
`define SMPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smpq assertion failed");

`else

`define SMPQ_ASSERT_NOW(label, ante, cons)
`define SMPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/smpq_pkg.sv]
package smpq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DATA_W = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] pri;
  } slot_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] pri;
  } cell_cmd_t;

endpackage

[design/smpq_cell.sv]
module smpq_cell (
  input  logic              clk,
  input  smpq_pkg::cell_cmd_t cmd,
  input  logic              occupied,
  input  logic              left_le,
  input  smpq_pkg::slot_t   left_slot,
  input  smpq_pkg::slot_t   right_slot,
  output logic              le,
  output smpq_pkg::slot_t   slot
);

  smpq_pkg::slot_t new_slot;

  // entry stays in place when it sorts at or before the new one
  assign le = occupied && ($signed(slot.pri) <= $signed(cmd.pri));

  assign new_slot.value = cmd.value;
  assign new_slot.pri   = cmd.pri;

  always_ff @(posedge clk) begin
    if (cmd.ins && !le) begin
      slot <= left_le ? new_slot : left_slot;
    end else if (cmd.rem) begin
      slot <= right_slot;
    end
  end

endmodule

[design/stable_min_priority_queue_core.sv]
// channel | valid    | stall     | word
// in      | in_valid | in_stall  | req_type, item_value, entry_priority
// out     | out_valid| out_stall | removed_value, removed_priority, status, occupancy
//
// One request per cycle while in_stall is low: every cell compares its priority with the
// new one in parallel and shifts by one slot, so the whole chain updates together.
// The result word sits in an output register in the cycle after acceptance.
// in_stall follows out_stall only while that register holds an untaken word.
// Synchronous reset empties the queue and the output register; slots are not cleared.
`include "stable_min_priority_queue_core_assert.svh"

module stable_min_priority_queue_core #(
  parameter int CAPACITY = smpq_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic signed [31:0] item_value,
  input  logic signed [31:0] entry_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] removed_value,
  output logic signed [31:0] removed_priority,
  output logic [1:0]  status,
  output logic [4:0]  occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_fire;
  logic             full;
  logic             empty;
  logic             do_ins;
  logic             do_rem;

  smpq_pkg::cell_cmd_t cmd;
  smpq_pkg::slot_t     slots [CAPACITY];
  logic                le    [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign do_ins   = in_fire && (req_type == smpq_pkg::REQ_INSERT) && !full;
  assign do_rem   = in_fire && (req_type == smpq_pkg::REQ_REMOVE) && !empty;

  assign cmd.ins   = do_ins;
  assign cmd.rem   = do_rem;
  assign cmd.value = item_value;
  assign cmd.pri   = entry_priority;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      smpq_pkg::slot_t left_slot;
      smpq_pkg::slot_t right_slot;
      logic            left_le;

      if (i == 0) begin : g_head
        assign left_slot = '0;
        assign left_le   = 1'b1;
      end else begin : g_body
        assign left_slot = slots[i-1];
        assign left_le   = le[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign right_slot = '0;
      end else begin : g_mid
        assign right_slot = slots[i+1];
      end

      smpq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (count > CNT_W'(i)),
        .left_le    (left_le),
        .left_slot  (left_slot),
        .right_slot (right_slot),
        .le         (le[i]),
        .slot       (slots[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_rem) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      occupancy <= 5'(count_next);
      if (do_rem) begin
        removed_value    <= slots[0].value;
        removed_priority <= slots[0].pri;
      end else begin
        removed_value    <= '0;
        removed_priority <= '0;
      end
      if (req_type == smpq_pkg::REQ_INSERT) begin
        status <= full ? smpq_pkg::ST_OVERFLOW : smpq_pkg::ST_DONE;
      end else begin
        status <= empty ? smpq_pkg::ST_UNDERFLOW : smpq_pkg::ST_DONE;
      end
    end
  end

  `SMPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `SMPQ_ASSERT_NEXT(a_ins_grows, do_ins, count == $past(count) + 1'b1)
  `SMPQ_ASSERT_NEXT(a_rem_shrinks, do_rem, count == $past(count) - 1'b1 && status == smpq_pkg::ST_DONE)
  `SMPQ_ASSERT_NEXT(a_fire_shows, in_fire, out_valid && occupancy == 5'(count))

endmodule
